// ===== sv/pote_pkg.sv =====
// shared constants and types for the play order table engine
package pote_pkg;

    localparam int MAX_TRACKS_DEF = 256;
    localparam int VAL_W          = 9;
    localparam int LFSR_W         = 16;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [VAL_W-1:0]  QLEN_SAT  = 9'h1FF;

    typedef enum logic [3:0] {
        M_SYNC  = 4'd0,
        M_CUR   = 4'd1,
        M_NEXT  = 4'd2,
        M_PREV  = 4'd3,
        M_SEL   = 4'd4,
        M_RAND  = 4'd5,
        M_QLEN  = 4'd6,
        M_QROW  = 4'd7,
        M_UP    = 4'd8,
        M_DOWN  = 4'd9,
        M_REM   = 4'd10,
        M_SHUF  = 4'd11
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_STATE    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_ARG      = 2'd3
    } status_t;

endpackage

// ===== sv/play_order_table_engine.sv =====
// top level: command sequencer of the play order table engine
// One command item is taken at a time; cmd_ready is low until its single result
// item has been registered. Select and a shuffle-mode change scan the order
// table one entry at a time, a read and then a compare per entry. Sync writes
// one identity entry per cycle. Every Fisher-Yates step runs the bit-serial
// modulo unit, then the swap reads entry k and entry j and writes them back
// crossed. Remove moves the tail up one entry at a time, a read and then a
// write per entry. The table is a single-port-read ram.
module play_order_table_engine #(
    parameter int MAX_TRACKS = pote_pkg::MAX_TRACKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  logic [3:0]                  mode,
    input  logic [pote_pkg::VAL_W-1:0]  value,
    input  logic                        store_ready,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [1:0]                  status,
    output logic [7:0]                  track_index,
    output logic [pote_pkg::VAL_W-1:0]  queue_length
);
    import pote_pkg::*;

    localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNT_W = $clog2(MAX_TRACKS + 1);
    localparam int SUM_W = ((CNT_W > VAL_W) ? CNT_W : VAL_W) + 2;
    localparam int TW    = (IDX_W > VAL_W) ? IDX_W : VAL_W;
    localparam int QW    = (CNT_W > VAL_W) ? CNT_W : VAL_W;

    typedef enum logic [18:0] {
        S_IDLE    = 19'h00001,
        S_EXEC    = 19'h00002,
        S_IDENT   = 19'h00004,
        S_SH_STEP = 19'h00008,
        S_SH_MOD  = 19'h00010,
        S_SH_RK   = 19'h00020,
        S_SH_RJ   = 19'h00040,
        S_SH_WK   = 19'h00080,
        S_SH_WJ   = 19'h00100,
        S_FD_RD   = 19'h00200,
        S_FD_CK   = 19'h00400,
        S_RM_RD   = 19'h00800,
        S_RM_WR   = 19'h01000,
        S_RD_OUT  = 19'h02000,
        S_RD_CAP  = 19'h04000,
        S_RD_CUR  = 19'h08000,
        S_CUR_CAP = 19'h10000,
        S_SYNC_END= 19'h20000,
        S_FIN     = 19'h40000
    } state_t;

    state_t            state_reg;
    mode_t             mode_reg;
    logic [VAL_W-1:0]  val_reg;
    logic              rdy_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  cursor_reg;
    logic              shuffle_reg;
    logic              repeat_reg;
    logic [LFSR_W-1:0] lfsr_reg;
    logic [CNT_W-1:0]  i_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [IDX_W-1:0]  a_reg;
    logic [TW-1:0]     target_reg;
    status_t           status_reg;
    logic [7:0]        trk_reg;
    logic              rsp_valid_reg;
    logic [1:0]        rsp_status_reg;
    logic [7:0]        rsp_trk_reg;
    logic [VAL_W-1:0]  rsp_qlen_reg;

    logic [SUM_W-1:0]  sum_cv;
    logic [SUM_W-1:0]  cnt_s;
    logic [IDX_W-1:0]  p_idx;
    logic [LFSR_W-1:0] lfsr_adv;
    logic [CNT_W-1:0]  i_inc;
    logic [QW-1:0]     qdiff;
    logic [VAL_W-1:0]  qlen;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [IDX_W-1:0]  ram_rdata;

    logic              mod_start;
    logic              mod_done;
    logic [CNT_W-1:0]  mod_rem;

    assign sum_cv   = SUM_W'(cursor_reg) + SUM_W'(val_reg);
    assign cnt_s    = SUM_W'(count_reg);
    assign p_idx    = sum_cv[IDX_W-1:0];
    assign lfsr_adv = {1'b0, lfsr_reg[LFSR_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
    assign i_inc    = i_reg + 1'b1;
    assign qdiff    = QW'(count_reg) - QW'(cursor_reg);

    always_comb
    begin
        if (!rdy_reg || count_reg == '0)
        begin
            qlen = '0;
        end
        else if (qdiff > QW'(QLEN_SAT))
        begin
            qlen = QLEN_SAT;
        end
        else
        begin
            qlen = VAL_W'(qdiff);
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = i_reg[IDX_W-1:0];
        ram_wdata = IDX_W'(i_reg);
        unique case (state_reg)
            S_IDENT:
            begin
                ram_we = (i_reg < count_reg);
            end
            S_SH_WK:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg;
                ram_wdata = ram_rdata;
            end
            S_SH_WJ:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = a_reg;
            end
            S_RM_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_SH_RK:  ram_raddr = k_reg;
            S_SH_RJ:  ram_raddr = j_reg;
            S_FD_RD:  ram_raddr = i_reg[IDX_W-1:0];
            S_RM_RD:  ram_raddr = i_inc[IDX_W-1:0];
            S_RD_OUT: ram_raddr = pos_reg;
            S_RD_CUR: ram_raddr = cursor_reg;
            default:  ram_raddr = '0;
        endcase
    end

    assign mod_start = (state_reg == S_SH_STEP) && (i_reg > CNT_W'(1));

    pote_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_TRACKS)
    ) u_order_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pote_mod #(
        .DIV_W (CNT_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (lfsr_adv),
        .divisor  (i_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            shuffle_reg   <= 1'b0;
            repeat_reg    <= 1'b1;
            lfsr_reg      <= LFSR_SEED;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                repeat_reg <= cfg_wr_data;
            end
            if (rsp_valid_reg && rsp_ready && state_reg != S_FIN)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_FIN;
                    if (!rdy_reg && mode_reg != M_QLEN && mode_reg != M_SHUF
                        && mode_reg <= M_SHUF)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        unique case (mode_reg)
                            M_SYNC:
                            begin
                                if (SUM_W'(val_reg) > SUM_W'(MAX_TRACKS))
                                begin
                                    count_reg <= CNT_W'(MAX_TRACKS);
                                end
                                else
                                begin
                                    count_reg <= CNT_W'(val_reg);
                                end
                                state_reg <= S_IDENT;
                            end
                            M_CUR:
                            begin
                                if (count_reg != '0)
                                begin
                                    state_reg <= S_RD_OUT;
                                end
                            end
                            M_NEXT:
                            begin
                                if (count_reg != '0)
                                begin
                                    if (SUM_W'(cursor_reg) + 1'b1 >= cnt_s)
                                    begin
                                        if (repeat_reg)
                                        begin
                                            cursor_reg <= '0;
                                            state_reg  <= S_RD_OUT;
                                        end
                                    end
                                    else
                                    begin
                                        cursor_reg <= cursor_reg + 1'b1;
                                        state_reg  <= S_RD_OUT;
                                    end
                                end
                            end
                            M_PREV:
                            begin
                                if (count_reg != '0)
                                begin
                                    if (cursor_reg == '0)
                                    begin
                                        if (repeat_reg)
                                        begin
                                            cursor_reg <= IDX_W'(count_reg - 1'b1);
                                            state_reg  <= S_RD_OUT;
                                        end
                                    end
                                    else
                                    begin
                                        cursor_reg <= cursor_reg - 1'b1;
                                        state_reg  <= S_RD_OUT;
                                    end
                                end
                            end
                            M_SEL:
                            begin
                                if (SUM_W'(val_reg) < cnt_s)
                                begin
                                    state_reg <= S_FD_RD;
                                end
                            end
                            M_RAND:
                            begin
                                if (count_reg != '0)
                                begin
                                    state_reg <= S_SH_STEP;
                                end
                            end
                            M_QROW:
                            begin
                                if (sum_cv < cnt_s)
                                begin
                                    state_reg <= S_RD_OUT;
                                end
                            end
                            M_UP:
                            begin
                                if (val_reg >= VAL_W'(2) && sum_cv < cnt_s)
                                begin
                                    state_reg <= S_SH_RK;
                                end
                            end
                            M_DOWN:
                            begin
                                if (val_reg != '0 && sum_cv + 1'b1 < cnt_s)
                                begin
                                    state_reg <= S_SH_RK;
                                end
                            end
                            M_REM:
                            begin
                                if (val_reg != '0 && sum_cv < cnt_s)
                                begin
                                    state_reg <= S_RM_RD;
                                end
                            end
                            M_SHUF:
                            begin
                                if ((val_reg != '0) != shuffle_reg)
                                begin
                                    shuffle_reg <= (val_reg != '0);
                                    if (rdy_reg && count_reg != '0)
                                    begin
                                        state_reg <= S_RD_CUR;
                                    end
                                end
                            end
                            default:
                            begin
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_IDENT:
                begin
                    if (i_reg >= count_reg)
                    begin
                        state_reg <= S_SH_STEP;
                    end
                end
                S_SH_STEP:
                begin
                    if (i_reg > CNT_W'(1))
                    begin
                        lfsr_reg  <= lfsr_adv;
                        state_reg <= S_SH_MOD;
                    end
                    else
                    begin
                        case (mode_reg)
                            M_SYNC:  state_reg <= S_SYNC_END;
                            M_RAND:
                            begin
                                cursor_reg <= '0;
                                state_reg  <= S_RD_OUT;
                            end
                            M_SHUF:  state_reg <= S_FD_RD;
                            default: state_reg <= S_FIN;
                        endcase
                    end
                end
                S_SH_MOD:
                begin
                    if (mod_done)
                    begin
                        state_reg <= S_SH_RK;
                    end
                end
                S_SH_RK:  state_reg <= S_SH_RJ;
                S_SH_RJ:  state_reg <= S_SH_WK;
                S_SH_WK:  state_reg <= S_SH_WJ;
                S_SH_WJ:
                begin
                    if (mode_reg == M_UP || mode_reg == M_DOWN)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_SH_STEP;
                    end
                end
                S_FD_RD:
                begin
                    if (i_reg < count_reg)
                    begin
                        state_reg <= S_FD_CK;
                    end
                    else
                    begin
                        if (mode_reg != M_SEL)
                        begin
                            cursor_reg <= '0;
                        end
                        state_reg <= S_FIN;
                    end
                end
                S_FD_CK:
                begin
                    if (TW'(ram_rdata) == target_reg)
                    begin
                        cursor_reg <= i_reg[IDX_W-1:0];
                        state_reg  <= (mode_reg == M_SEL) ? S_RD_OUT : S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_FD_RD;
                    end
                end
                S_RM_RD:
                begin
                    if (i_inc < count_reg)
                    begin
                        state_reg <= S_RM_WR;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_FIN;
                    end
                end
                S_RM_WR:  state_reg <= S_RM_RD;
                S_RD_OUT: state_reg <= S_RD_CAP;
                S_RD_CAP: state_reg <= S_FIN;
                S_RD_CUR: state_reg <= S_CUR_CAP;
                S_CUR_CAP: state_reg <= S_IDENT;
                S_SYNC_END:
                begin
                    if (count_reg == '0)
                    begin
                        cursor_reg <= '0;
                    end
                    else if (CNT_W'(cursor_reg) >= count_reg)
                    begin
                        cursor_reg <= IDX_W'(count_reg - 1'b1);
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                mode_reg <= mode_t'(mode);
                val_reg  <= value;
                rdy_reg  <= store_ready;
            end
            S_EXEC:
            begin
                status_reg <= ST_OK;
                trk_reg    <= '0;
                i_reg      <= '0;
                pos_reg    <= cursor_reg;
                target_reg <= TW'(val_reg);
                k_reg      <= p_idx;
                j_reg      <= (mode_reg == M_UP) ? p_idx - 1'b1 : p_idx + 1'b1;
                if (!rdy_reg && mode_reg != M_QLEN && mode_reg != M_SHUF
                    && mode_reg <= M_SHUF)
                begin
                    status_reg <= ST_STATE;
                end
                else
                begin
                    unique case (mode_reg)
                        M_SYNC, M_QLEN, M_SHUF:
                        begin
                            status_reg <= ST_OK;
                        end
                        M_CUR:
                        begin
                            if (count_reg == '0)
                            begin
                                status_reg <= ST_NOTFOUND;
                            end
                        end
                        M_NEXT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_reg <= ST_NOTFOUND;
                            end
                            else if (SUM_W'(cursor_reg) + 1'b1 >= cnt_s)
                            begin
                                pos_reg <= '0;
                                if (!repeat_reg)
                                begin
                                    status_reg <= ST_NOTFOUND;
                                end
                            end
                            else
                            begin
                                pos_reg <= cursor_reg + 1'b1;
                            end
                        end
                        M_PREV:
                        begin
                            if (count_reg == '0)
                            begin
                                status_reg <= ST_NOTFOUND;
                            end
                            else if (cursor_reg == '0)
                            begin
                                pos_reg <= IDX_W'(count_reg - 1'b1);
                                if (!repeat_reg)
                                begin
                                    status_reg <= ST_NOTFOUND;
                                end
                            end
                            else
                            begin
                                pos_reg <= cursor_reg - 1'b1;
                            end
                        end
                        M_SEL:
                        begin
                            if (SUM_W'(val_reg) >= cnt_s)
                            begin
                                status_reg <= ST_ARG;
                            end
                        end
                        M_RAND:
                        begin
                            i_reg <= count_reg;
                            if (count_reg == '0)
                            begin
                                status_reg <= ST_NOTFOUND;
                            end
                        end
                        M_QROW:
                        begin
                            pos_reg <= p_idx;
                            if (sum_cv >= cnt_s)
                            begin
                                status_reg <= ST_NOTFOUND;
                            end
                        end
                        M_UP:
                        begin
                            if (val_reg < VAL_W'(2) || sum_cv >= cnt_s)
                            begin
                                status_reg <= ST_ARG;
                            end
                        end
                        M_DOWN:
                        begin
                            if (val_reg == '0 || sum_cv + 1'b1 >= cnt_s)
                            begin
                                status_reg <= ST_ARG;
                            end
                        end
                        M_REM:
                        begin
                            i_reg <= CNT_W'(sum_cv);
                            if (val_reg == '0 || sum_cv >= cnt_s)
                            begin
                                status_reg <= ST_ARG;
                            end
                        end
                        default:
                        begin
                            status_reg <= ST_ARG;
                        end
                    endcase
                end
            end
            S_IDENT:
            begin
                if (i_reg < count_reg)
                begin
                    i_reg <= i_inc;
                end
                else
                begin
                    i_reg <= shuffle_reg ? count_reg : '0;
                end
            end
            S_SH_STEP:
            begin
                k_reg   <= IDX_W'(i_reg - 1'b1);
                pos_reg <= '0;
                if (i_reg <= CNT_W'(1))
                begin
                    i_reg <= '0;
                end
            end
            S_SH_MOD:
            begin
                j_reg <= mod_rem[IDX_W-1:0];
            end
            S_SH_RJ:
            begin
                a_reg <= ram_rdata;
            end
            S_SH_WJ:
            begin
                i_reg <= i_reg - 1'b1;
            end
            S_FD_CK:
            begin
                pos_reg <= i_reg[IDX_W-1:0];
                i_reg   <= i_inc;
            end
            S_FD_RD:
            begin
                if (i_reg >= count_reg && mode_reg == M_SEL)
                begin
                    status_reg <= ST_NOTFOUND;
                end
            end
            S_RM_WR:
            begin
                i_reg <= i_inc;
            end
            S_RD_CAP:
            begin
                trk_reg <= 8'(ram_rdata);
            end
            S_CUR_CAP:
            begin
                target_reg <= TW'(ram_rdata);
                i_reg      <= '0;
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_status_reg <= status_reg;
                    rsp_trk_reg    <= (status_reg == ST_OK) ? trk_reg : '0;
                    rsp_qlen_reg   <= qlen;
                end
            end
            default:
            begin
                a_reg <= a_reg;
            end
        endcase
    end

    assign cmd_ready    = (state_reg == S_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign status       = rsp_status_reg;
    assign track_index  = rsp_trk_reg;
    assign queue_length = rsp_qlen_reg;

endmodule

// ===== sv/pote_ram.sv =====
// generic single write port ram with registered read
module pote_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/pote_mod.sv =====
// bit serial restoring modulo unit, one dividend bit per cycle
module pote_mod #(
    parameter int DIV_W = 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pote_pkg::LFSR_W-1:0]  dividend,
    input  logic [DIV_W-1:0]             divisor,
    output logic                         done,
    output logic [DIV_W-1:0]             rem
);
    import pote_pkg::*;

    localparam int CW = $clog2(LFSR_W);
    localparam logic [CW-1:0] LAST = CW'(LFSR_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [LFSR_W-1:0] dvd_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dsr_reg;
    logic [DIV_W:0]    rem_shift;
    logic [DIV_W-1:0]  rem_next;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[LFSR_W-1]};
        if (rem_shift >= {1'b0, dsr_reg})
        begin
            rem_next = DIV_W'(rem_shift - {1'b0, dsr_reg});
        end
        else
        begin
            rem_next = DIV_W'(rem_shift);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[LFSR_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== sv/pote_chk.sv =====
// port level checker for the play order table engine, bound to the top level
module pote_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_wr_en,
    input logic       cfg_wr_data,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic [3:0] mode,
    input logic [8:0] value,
    input logic       store_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] status,
    input logic [7:0] track_index,
    input logic [8:0] queue_length
);
    import pote_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(track_index) && $stable(queue_length))
        else $error("response changed while stalled");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("new item taken while busy");

    a_trk_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> track_index == 8'd0)
        else $error("track index nonzero on error");

    a_qlen_zero_on_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_STATE |-> queue_length == 9'd0)
        else $error("queue length nonzero on invalid state");

endmodule

bind play_order_table_engine pote_chk u_pote_chk (.*);
